[design/lmde_pkg.sv]
// Shared types and constants of the LED matrix draw engine.
`default_nettype none

package lmde_pkg;

    // Command kinds carried on the input tuser field.
    typedef enum logic [2:0] {
        KIND_CLEAR   = 3'd0,
        KIND_POINT   = 3'd1,
        KIND_HLINE   = 3'd2,
        KIND_VLINE   = 3'd3,
        KIND_RECT    = 3'd4,
        KIND_FILL    = 3'd5,
        KIND_READ    = 3'd6
    } kind_t;

    // Width of the color fields at the ports.
    localparam int COLOR_BITS = 24;

    // Width used for bounds arithmetic; holds any coordinate sum up to 64 + 31.
    localparam int BOUND_BITS = 7;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init;      // load the whole screen with black for the power-up sweep
        logic load;      // latch a new request and check its bounds
        logic step;      // visit the current pixel of the sweep and advance
        logic rd;        // issue a read of the addressed pixel
        logic res_load;  // move the outcome into the result register
    } lmde_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ok;        // latched request passed its bounds check
        logic is_read;   // latched request is a pixel read
        logic last;      // the sweep stands on its final pixel
    } lmde_status_t;

endpackage

`default_nettype wire

[design/led_matrix_draw_engine_top.sv]
// Top level of the LED matrix draw engine.
//
//   Channel   Direction  Payload
//   s_axis    in         tuser = kind; tdata = coordinates, sizes and draw color
//   m_axis    out        tuser = accepted; tdata = read color
//
// One request is worked on at a time. A sweep visits one pixel per cycle through the
// single port of the pixel store and covers the bounding box of a draw, or the whole
// screen for a clear. A read makes one access to the store, and a rejected request goes
// straight to the result. After reset a clearing pass blacks out the store while
// s_axis_tready stays low. A stalled m_axis holds the finished result; the next request
// is taken meanwhile and waits at its end for the output register to free.
`default_nettype none

module led_matrix_draw_engine_top
    import lmde_pkg::*;
#(
    parameter int COLUMNS      = 12,
    parameter int ROWS         = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [3:0] x_start, [7:4] y_start, [11:8] x_end, [15:12] y_end,
    // [20:16] rect_width, [25:21] rect_height, [49:26] draw_color, [55:50] zero
    input  wire logic [55:0] s_axis_tdata,
    // [2:0] kind
    input  wire logic [2:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [23:0] read_color
    output logic [23:0]      m_axis_tdata,
    // [0] accepted
    output logic             m_axis_tuser
);

    lmde_cmd_t    cmd;
    lmde_status_t status;

    lmde_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    lmde_datapath #(
        .COLUMNS      (COLUMNS),
        .ROWS         (ROWS),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk         (clk),
        .cmd         (cmd),
        .status      (status),
        .kind        (s_axis_tuser),
        .x_start     (s_axis_tdata[3:0]),
        .y_start     (s_axis_tdata[7:4]),
        .x_end       (s_axis_tdata[11:8]),
        .y_end       (s_axis_tdata[15:12]),
        .rect_width  (s_axis_tdata[20:16]),
        .rect_height (s_axis_tdata[25:21]),
        .draw_color  (s_axis_tdata[49:26]),
        .accepted    (m_axis_tuser),
        .read_color  (m_axis_tdata)
    );

endmodule

`default_nettype wire

[design/lmde_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module lmde_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 192
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                       wdata,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[design/lmde_datapath.sv]
// Datapath of the draw engine: bounds check, pixel sweep counters, pixel store and result.
`default_nettype none

module lmde_datapath
    import lmde_pkg::*;
#(
    parameter int COLUMNS      = 12,
    parameter int ROWS         = 16,
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                  clk,
    input  wire lmde_cmd_t             cmd,
    output lmde_status_t               status,
    input  wire logic [2:0]            kind,
    input  wire logic [3:0]            x_start,
    input  wire logic [3:0]            y_start,
    input  wire logic [3:0]            x_end,
    input  wire logic [3:0]            y_end,
    input  wire logic [4:0]            rect_width,
    input  wire logic [4:0]            rect_height,
    input  wire logic [COLOR_BITS-1:0] draw_color,
    output logic                       accepted,
    output logic [COLOR_BITS-1:0]      read_color
);

    localparam int PIXELS = COLUMNS * ROWS;
    localparam int XW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int YW     = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
    localparam int MW     = AW + BOUND_BITS;
    localparam int PW     = 3 * CHANNEL_BITS;

    localparam logic [BOUND_BITS-1:0] COL_LIMIT = BOUND_BITS'(COLUMNS);
    localparam logic [BOUND_BITS-1:0] ROW_LIMIT = BOUND_BITS'(ROWS);
    localparam logic [XW-1:0]         X_LAST    = XW'(COLUMNS - 1);
    localparam logic [YW-1:0]         Y_LAST    = YW'(ROWS - 1);

    logic [BOUND_BITS-1:0] xs_w, ys_w, xe_w, ye_w, w_w, h_w;
    logic                  start_in;
    logic                  ok_next, read_next, outline_next;
    logic [XW-1:0]         x0_next, x1_next;
    logic [YW-1:0]         y0_next, y1_next;

    logic                  ok_reg, read_reg, outline_reg;
    logic [XW-1:0]         x0_reg, x1_reg, cx_reg;
    logic [YW-1:0]         y0_reg, y1_reg, cy_reg;
    logic [PW-1:0]         color_reg;
    logic                  accepted_reg;
    logic [COLOR_BITS-1:0] read_color_reg;

    logic                  on_border;
    logic                  ram_we;
    logic [AW-1:0]         addr;
    logic [PW-1:0]         rdata;

    assign xs_w = BOUND_BITS'(x_start);
    assign ys_w = BOUND_BITS'(y_start);
    assign xe_w = BOUND_BITS'(x_end);
    assign ye_w = BOUND_BITS'(y_end);
    assign w_w  = BOUND_BITS'(rect_width);
    assign h_w  = BOUND_BITS'(rect_height);

    assign start_in = (xs_w < COL_LIMIT) && (ys_w < ROW_LIMIT);

    // Bounds check and the box that the sweep walks for each kind.
    always_comb
    begin
        ok_next      = 1'b0;
        read_next    = 1'b0;
        outline_next = 1'b0;
        x0_next      = XW'(x_start);
        y0_next      = YW'(y_start);
        x1_next      = XW'(x_start);
        y1_next      = YW'(y_start);
        case (kind_t'(kind))
            KIND_CLEAR:
            begin
                ok_next = 1'b1;
                x0_next = '0;
                y0_next = '0;
                x1_next = X_LAST;
                y1_next = Y_LAST;
            end
            KIND_POINT:
            begin
                ok_next = start_in;
            end
            KIND_HLINE:
            begin
                // The end column must be at least one.
                ok_next = start_in && (x_end != 4'd0) && (xe_w < COL_LIMIT)
                          && (x_start <= x_end);
                x1_next = XW'(x_end);
            end
            KIND_VLINE:
            begin
                ok_next = start_in && (y_end != 4'd0) && (ye_w < ROW_LIMIT)
                          && (y_start <= y_end);
                y1_next = YW'(y_end);
            end
            KIND_RECT, KIND_FILL:
            begin
                ok_next = start_in && (rect_width != 5'd0) && (w_w + xs_w <= COL_LIMIT)
                          && (rect_height != 5'd0) && (h_w + ys_w <= ROW_LIMIT);
                outline_next = (kind_t'(kind) == KIND_RECT);
                x1_next = XW'(xs_w + w_w - BOUND_BITS'(1));
                y1_next = YW'(ys_w + h_w - BOUND_BITS'(1));
            end
            KIND_READ:
            begin
                ok_next   = start_in;
                read_next = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.init)
        begin
            ok_reg      <= 1'b1;
            read_reg    <= 1'b0;
            outline_reg <= 1'b0;
            x0_reg      <= '0;
            y0_reg      <= '0;
            x1_reg      <= X_LAST;
            y1_reg      <= Y_LAST;
            cx_reg      <= '0;
            cy_reg      <= '0;
            color_reg   <= '0;
        end
        else if (cmd.load)
        begin
            ok_reg      <= ok_next;
            read_reg    <= read_next;
            outline_reg <= outline_next;
            x0_reg      <= x0_next;
            y0_reg      <= y0_next;
            x1_reg      <= x1_next;
            y1_reg      <= y1_next;
            cx_reg      <= x0_next;
            cy_reg      <= y0_next;
            // A clear paints black whatever color the request carries.
            color_reg   <= (kind_t'(kind) == KIND_CLEAR) ? '0 : PW'(draw_color);
        end
        else if (cmd.step && !status.last)
        begin
            if (cx_reg == x1_reg)
            begin
                cx_reg <= x0_reg;
                cy_reg <= cy_reg + YW'(1);
            end
            else
            begin
                cx_reg <= cx_reg + XW'(1);
            end
        end

        if (cmd.res_load)
        begin
            accepted_reg   <= ok_reg;
            read_color_reg <= (ok_reg && read_reg) ? COLOR_BITS'(rdata) : '0;
        end
    end

    // An outline only touches pixels on the edge of its box.
    assign on_border = !outline_reg || (cx_reg == x0_reg) || (cx_reg == x1_reg)
                       || (cy_reg == y0_reg) || (cy_reg == y1_reg);

    assign ram_we = cmd.step && on_border;
    assign addr   = AW'(MW'(cy_reg) * MW'(COLUMNS) + MW'(cx_reg));

    lmde_ram #(
        .WIDTH (PW),
        .DEPTH (PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.rd),
        .addr  (addr),
        .wdata (color_reg),
        .rdata (rdata)
    );

    assign status.ok      = ok_reg;
    assign status.is_read = read_reg;
    assign status.last    = (cx_reg == x1_reg) && (cy_reg == y1_reg);

    assign accepted   = accepted_reg;
    assign read_color = read_color_reg;

endmodule

`default_nettype wire

[design/lmde_ctrl.sv]
// Controller state machine of the draw engine.
`default_nettype none

module lmde_ctrl
    import lmde_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  wire logic         out_ready,
    output lmde_cmd_t         cmd,
    input  wire lmde_status_t status
);

    typedef enum logic [2:0] {
        S_BOOT,
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_SWEEP,
        S_READ,
        S_READ_DATA,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd          = '0;
        cmd.init     = (state_reg == S_BOOT);
        cmd.load     = (state_reg == S_IDLE) && in_valid;
        cmd.step     = (state_reg == S_INIT) || (state_reg == S_SWEEP);
        cmd.rd       = (state_reg == S_READ);
        cmd.res_load = (state_reg == S_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_BOOT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_BOOT:
                begin
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    // Power-up sweep blacks out the store and reports nothing.
                    if (status.last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (!status.ok)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (status.is_read)
                    begin
                        state_reg <= S_READ;
                    end
                    else
                    begin
                        state_reg <= S_SWEEP;
                    end
                end
                S_SWEEP:
                begin
                    if (status.last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_READ_DATA;
                end
                S_READ_DATA:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_BOOT;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
